@@ rtl/bfa_pkg.sv @@
package bfa_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_W     = 32;
	localparam int MAP_DEPTH  = MAX_BLOCKS / WORD_W;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);
	localparam int BIT_AW     = $clog2(WORD_W);
	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [1:0] REQ_TOGGLE = 2'd0;
	localparam logic [1:0] REQ_TEST   = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;

	localparam logic [0:0] REG_BLOCK_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] block_index;
		logic [CNT_W-1:0] run_length;
	} bfa_req_t;

	typedef struct packed {
		logic             bit_value;
		logic             found;
		logic [IDX_W-1:0] run_start;
		logic             out_of_range;
	} bfa_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_MODIFY,
		ST_SEARCH,
		ST_FIX,
		ST_RESULT
	} bfa_state_t;

	typedef struct packed {
		logic clear;
		logic latch;
		logic access;
		logic modify;
		logic scan;
		logic fix;
		logic load;
	} bfa_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_rw;
		logic in_scan;
		logic scan_hit;
		logic scan_end;
		logic out_free;
	} bfa_sts_t;

endpackage

@@ rtl/bitmap_first_fit_run_allocator.sv @@
// Channel  Direction  Handshake                  Word
// cfg      in/out     psel penable pwrite pready  paddr pwdata prdata (block_count)
// req      in         req_valid / req_stall      req (req_type, block_index, run_length)
// rsp      out        rsp_valid / rsp_stall      rsp (bit_value, found, run_start, out_of_range)
//
// After reset all 128 bitmap words are swept to zero, during which req_stall stays high.
// A toggle or test passes ST_ACCESS and ST_MODIFY, then loads the result in ST_RESULT.
// A search reads one 32-bit bitmap word per cycle and, once the scan ends, loads the result
// register in ST_RESULT; a hit ends the scan at the word that holds the end of the run.
// One word is in work at a time; the next word is accepted while a result waits in the
// output register, and only a second finished result waits for rsp_stall to drop.
module bitmap_first_fit_run_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bfa_pkg::APB_AW-1:0] paddr,
	input  logic [bfa_pkg::APB_DW-1:0] pwdata,
	output logic [bfa_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  bfa_pkg::bfa_req_t          req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output bfa_pkg::bfa_rsp_t          rsp
);
	import bfa_pkg::*;

	logic [CNT_W-1:0] block_count_q;
	logic             reg_sel;
	bfa_cmd_t         cmd;
	bfa_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_AW-1:2] == REG_BLOCK_COUNT;
	assign prdata  = reg_sel ? APB_DW'(block_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= CNT_W'(MAX_BLOCKS);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			block_count_q <= pwdata[CNT_W-1:0];
		end
	end

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.block_count(block_count_q),
		.cmd        (cmd),
		.sts        (sts),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

@@ rtl/bfa_ram.sv @@
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/bfa_ctrl.sv @@
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bfa_pkg::bfa_sts_t sts,
	output bfa_pkg::bfa_cmd_t cmd
);
	import bfa_pkg::*;

	bfa_state_t state_q;
	bfa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.latch = 1'b1;
					if (sts.in_rw) begin
						state_d = ST_ACCESS;
					end else if (sts.in_scan) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = ST_MODIFY;
			end
			ST_MODIFY: begin
				cmd.modify = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_SEARCH: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					state_d = ST_FIX;
				end else if (sts.scan_end) begin
					state_d = ST_RESULT;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/bfa_dp.sv @@
module bfa_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bfa_pkg::bfa_req_t         req,
	input  logic [bfa_pkg::CNT_W-1:0] block_count,
	input  bfa_pkg::bfa_cmd_t         cmd,
	output bfa_pkg::bfa_sts_t         sts,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output bfa_pkg::bfa_rsp_t         rsp
);
	import bfa_pkg::*;

	logic [MAP_AW-1:0]  clr_cnt_q;
	bfa_req_t           req_q;
	logic [CNT_W-1:0]   limit_q;
	logic [MAP_AW:0]    rd_addr_q;
	logic               rd_vld_s1;
	logic [MAP_AW-1:0]  rd_word_s1;
	logic [CNT_W-1:0]   carry_q;
	logic [IDX_W-1:0]   end_pos_q;
	bfa_rsp_t           res_q;
	bfa_rsp_t           rsp_q;
	logic               rsp_valid_q;

	logic [CNT_W-1:0]   limit;
	logic [CNT_W:0]     lim_up;
	logic [MAP_AW:0]    nwords;
	logic               issue;
	logic               oor;
	logic               is_toggle;
	logic [WORD_W-1:0]  bit_mask;
	logic               new_bit;
	logic [CNT_W-1:0]   start_full;

	logic               we;
	logic [MAP_AW-1:0]  waddr;
	logic [WORD_W-1:0]  wdata;
	logic [MAP_AW-1:0]  raddr;
	logic [WORD_W-1:0]  rdata;

	logic [WORD_W-1:0]  lane_ok;
	logic [WORD_W-1:0]  used;
	logic [WORD_W-1:0]  hit;
	logic [CNT_W-1:0]   run_end [WORD_W];
	logic               seen;
	logic [BIT_AW-1:0]  last;
	logic [BIT_AW-1:0]  span;
	logic [BIT_AW-1:0]  hit_j;
	logic [MAP_AW:0]    word_ext;

	bfa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign limit  = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;
	assign lim_up = {1'b0, limit_q} + (CNT_W+1)'(WORD_W - 1);
	assign nwords = lim_up[CNT_W-1:BIT_AW];
	assign issue  = rd_addr_q < nwords;

	assign is_toggle = req_q.req_type == REQ_TOGGLE;
	assign oor       = {1'b0, req_q.block_index} >= limit_q;
	assign bit_mask  = WORD_W'(1) << req_q.block_index[BIT_AW-1:0];
	assign new_bit   = rdata[req_q.block_index[BIT_AW-1:0]] ^ is_toggle;

	assign start_full = {1'b0, end_pos_q} + CNT_W'(1) - req_q.run_length;

	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = '0;
		raddr = rd_addr_q[MAP_AW-1:0];
		if (cmd.clear) begin
			we = 1'b1;
		end
		if (cmd.access) begin
			raddr = req_q.block_index[IDX_W-1:BIT_AW];
		end
		if (cmd.modify) begin
			waddr = req_q.block_index[IDX_W-1:BIT_AW];
			wdata = rdata ^ bit_mask;
			we    = is_toggle && !oor;
		end
	end

	// Each lane finds the free run that ends at its bit, carrying the run
	// left open at the top of the previous word.
	always_comb begin
		seen     = 1'b0;
		last     = '0;
		span     = '0;
		hit_j    = '0;
		word_ext = {1'b0, rd_word_s1};
		for (int j = 0; j < WORD_W; j++) begin
			lane_ok[j] = (word_ext < limit_q[CNT_W-1:BIT_AW]) ||
				((word_ext == limit_q[CNT_W-1:BIT_AW]) &&
				(BIT_AW'(j) < limit_q[BIT_AW-1:0]));
			used[j] = rdata[j] | ~lane_ok[j];
		end
		for (int j = 0; j < WORD_W; j++) begin
			seen = 1'b0;
			last = '0;
			for (int k = 0; k <= j; k++) begin
				if (used[k]) begin
					seen = 1'b1;
					last = BIT_AW'(k);
				end
			end
			span       = BIT_AW'(j) - last;
			run_end[j] = seen ? CNT_W'(span) : carry_q + CNT_W'(j + 1);
			hit[j]     = run_end[j] == req_q.run_length;
		end
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_j = BIT_AW'(j);
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.clear_done = clr_cnt_q == {MAP_AW{1'b1}};
		sts.in_rw      = (req.req_type == REQ_TOGGLE) || (req.req_type == REQ_TEST);
		sts.in_scan    = (req.req_type == REQ_FIND) && (req.run_length != '0) &&
			(limit != '0);
		sts.scan_hit   = rd_vld_s1 && (|hit);
		sts.scan_end   = !rd_vld_s1 && !issue;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
			end
			if (cmd.latch) begin
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= issue;
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q     <= req;
			limit_q   <= limit;
			rd_addr_q <= '0;
			carry_q   <= '0;
			res_q     <= '0;
		end
		if (cmd.modify) begin
			res_q.out_of_range <= oor;
			res_q.bit_value    <= !oor && new_bit;
		end
		if (cmd.scan) begin
			if (issue) begin
				rd_addr_q <= rd_addr_q + (MAP_AW+1)'(1);
			end
			rd_word_s1 <= rd_addr_q[MAP_AW-1:0];
			if (rd_vld_s1) begin
				carry_q <= run_end[WORD_W-1];
				if (|hit) begin
					res_q.found <= 1'b1;
					end_pos_q   <= {rd_word_s1, hit_j};
				end
			end
		end
		if (cmd.fix) begin
			res_q.run_start <= start_full[IDX_W-1:0];
		end
		if (cmd.load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/bfa_checker.sv @@
module bfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input bfa_pkg::bfa_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input bfa_pkg::bfa_rsp_t rsp
);
	import bfa_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request word taken while one is in work");

	a_new_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result word appeared without work in progress");

	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> !rsp.bit_value && !rsp.found &&
			(rsp.run_start == '0))
		else $error("out of range result carries data");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.run_start == '0)
		else $error("run start set without a found run");

endmodule

bind bitmap_first_fit_run_allocator bfa_checker u_bfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

@@ test/bitmap_first_fit_run_allocator_tb.sv @@
package bitmap_tb_pkg;

	import bfa_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	class bitmap_scoreboard;
		bit used[MAX_BLOCKS];
		bit [CNT_W-1:0] blocks;
		bfa_rsp_t pending_answers[$];
		int fail_count;

		function new();
			blocks = CNT_W'(MAX_BLOCKS);
			fail_count = 0;
		endfunction

		function void set_block_count(bit [CNT_W-1:0] value);
			blocks = value;
		endfunction

		function int unsigned effective_count();
			return (blocks > MAX_BLOCKS) ? MAX_BLOCKS : blocks;
		endfunction

		function bfa_rsp_t predict_answer(bfa_req_t r);
			bfa_rsp_t a;
			int unsigned lim;
			int unsigned run;
			int unsigned first;
			a = '0;
			lim = effective_count();
			run = 0;
			first = 0;
			case (r.req_type)
				REQ_TOGGLE, REQ_TEST: begin
					if (r.block_index >= lim) begin
						a.out_of_range = 1'b1;
					end else begin
						if (r.req_type == REQ_TOGGLE)
							used[r.block_index] = ~used[r.block_index];
						a.bit_value = used[r.block_index];
					end
				end
				REQ_FIND: begin
					if (r.run_length != 0) begin
						for (int unsigned i = 0; i < lim; i++) begin
							if (!used[i]) begin
								if (run == 0)
									first = i;
								run++;
								if (run == r.run_length) begin
									a.found = 1'b1;
									a.run_start = first[IDX_W-1:0];
									break;
								end
							end else begin
								run = 0;
							end
						end
					end
				end
				default: ;
			endcase
			return a;
		endfunction

		function void note_request(bfa_req_t r);
			pending_answers.push_back(predict_answer(r));
		endfunction

		function void complain(string what, logic [31:0] want, logic [31:0] got);
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		function void check_answer(bfa_rsp_t got);
			bfa_rsp_t want;
			if (pending_answers.size() == 0) begin
				complain("unexpected response word", 32'(0), 32'(got));
				return;
			end
			want = pending_answers.pop_front();
			if (got.bit_value !== want.bit_value)
				complain("bit_value", 32'(want.bit_value), 32'(got.bit_value));
			if (got.found !== want.found)
				complain("found", 32'(want.found), 32'(got.found));
			if (got.run_start !== want.run_start)
				complain("run_start", 32'(want.run_start), 32'(got.run_start));
			if (got.out_of_range !== want.out_of_range)
				complain("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range));
		endfunction

		function int outstanding();
			return pending_answers.size();
		endfunction
	endclass

endpackage

module bitmap_first_fit_run_allocator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bfa_pkg::*;
	import bitmap_tb_pkg::*;

	localparam logic [APB_AW-1:0] BLOCK_COUNT_ADDR = {REG_BLOCK_COUNT, 2'b00};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              req_valid = 1'b0;
	logic              req_stall;
	bfa_req_t          req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	bfa_rsp_t          rsp;

	bitmap_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;

	bitmap_first_fit_run_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_done != hold_asked) begin
			hold_left = 600;
			hold_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall = 1'b1;
		end else begin
			rsp_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_answer(rsp);
	end

	function automatic bfa_req_t make_req(logic [1:0] kind, int unsigned idx, int unsigned len);
		bfa_req_t r;
		r.req_type = kind;
		r.block_index = idx[IDX_W-1:0];
		r.run_length = len[CNT_W-1:0];
		return r;
	endfunction

	function automatic bfa_req_t random_request(int unsigned lim);
		int unsigned pick;
		int unsigned win;
		logic [1:0] kind;
		int unsigned idx;
		int unsigned len;
		pick = $urandom_range(99);
		if (pick < 38)
			kind = REQ_TOGGLE;
		else if (pick < 58)
			kind = REQ_TEST;
		else if (pick < 96)
			kind = REQ_FIND;
		else
			kind = REQ_UNUSED;
		win = (lim == 0) ? 1 : ((lim > 256) ? 256 : lim);
		pick = $urandom_range(99);
		if (pick < 70)
			idx = $urandom_range(win - 1, 0);
		else if (pick < 90)
			idx = $urandom_range(MAX_BLOCKS - 1, 0);
		else
			idx = (lim >= MAX_BLOCKS) ? MAX_BLOCKS - 1 : lim;
		pick = $urandom_range(99);
		if (pick < 55)
			len = $urandom_range(8, 1);
		else if (pick < 75)
			len = $urandom_range(48, 1);
		else if (pick < 85)
			len = $urandom_range(8191, 0);
		else if (pick < 90)
			len = 0;
		else if (pick < 95)
			len = lim;
		else
			len = lim + 1;
		return make_req(kind, idx, len);
	endfunction

	task automatic offer(bfa_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (sb.outstanding() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_block_count(bit [CNT_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = BLOCK_COUNT_ADDR;
		pwdata = APB_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== APB_DW'(value))
			sb.complain("block_count readback", APB_DW'(value), prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		sb.set_block_count(value);
	endtask

	task automatic run_phase(bit [CNT_W-1:0] count, int sender_pct, int receiver_pct,
			int items, bit squeeze);
		write_block_count(count);
		send_idle_pct = sender_pct;
		stall_pct = receiver_pct;
		if (squeeze)
			hold_asked++;
		repeat (items)
			offer(random_request(sb.effective_count()));
		drain();
	endtask

	initial begin
		int unsigned wait_cycles;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_block_count(13'd4096);
		offer(make_req(REQ_FIND, 0, 1));
		offer(make_req(REQ_FIND, 0, 4096));
		offer(make_req(REQ_FIND, 4095, 4097));
		offer(make_req(REQ_FIND, 0, 0));
		offer(make_req(REQ_FIND, 0, 8191));
		offer(make_req(REQ_TEST, 4095, 0));
		offer(make_req(REQ_TOGGLE, 4095, 0));
		offer(make_req(REQ_TOGGLE, 0, 8191));
		offer(make_req(REQ_TEST, 0, 0));
		offer(make_req(REQ_FIND, 0, 4095));
		offer(make_req(REQ_FIND, 0, 4094));
		offer(make_req(REQ_TOGGLE, 5, 0));
		offer(make_req(REQ_FIND, 0, 4));
		offer(make_req(REQ_FIND, 0, 5));
		offer(make_req(REQ_UNUSED, 4095, 8191));
		drain();
		write_block_count(13'd0);
		offer(make_req(REQ_TOGGLE, 0, 0));
		offer(make_req(REQ_TEST, 4095, 0));
		offer(make_req(REQ_FIND, 0, 1));
		drain();
		write_block_count(13'd8191);
		offer(make_req(REQ_TEST, 4095, 0));
		offer(make_req(REQ_TOGGLE, 4095, 0));
		offer(make_req(REQ_FIND, 0, 4090));
		drain();
		write_block_count(13'd1);
		offer(make_req(REQ_TEST, 1, 0));
		offer(make_req(REQ_TOGGLE, 0, 0));
		offer(make_req(REQ_FIND, 0, 1));
		offer(make_req(REQ_FIND, 0, 2));
		drain();

		run_phase(13'd4096, 0, 0, 220, 1'b0);
		run_phase(13'd0, 9, 9, 40, 1'b0);
		run_phase(13'd100, 58, 0, 200, 1'b0);
		run_phase(13'd33, 0, 58, 200, 1'b0);
		run_phase(13'd8191, 0, 0, 200, 1'b1);
		run_phase(13'd1, 9, 9, 60, 1'b0);
		run_phase(13'd4095, 0, 58, 200, 1'b0);
		run_phase(13'($urandom_range(8191, 0)), 58, 0, 200, 1'b0);
		run_phase(13'd64, 9, 9, 200, 1'b0);
		run_phase(13'd32, 0, 0, 150, 1'b0);

		req_valid = 1'b0;
		wait_cycles = 0;
		while (sb.outstanding() > 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (200) @(negedge clk);
		if (sb.fail_count == 0 && sb.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_ctrl.sv
rtl/bfa_dp.sv
rtl/bitmap_first_fit_run_allocator.sv
rtl/bfa_checker.sv
test/bitmap_first_fit_run_allocator_tb.sv
